@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising edge of clk, held off while rst_n is low
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in config line tokenizer");

// checked on every rising edge of clk, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed in config line tokenizer");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ design/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg
// types and constants of the configuration line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODE_W  = 9;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'd34;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'd92;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;

  localparam logic [CODE_W-1:0] TERM_A_RST = 9'd61;
  localparam logic [CODE_W-1:0] TERM_B_RST = 9'd256;
  localparam logic [CODE_W-1:0] COMM_A_RST = 9'd35;
  localparam logic [CODE_W-1:0] COMM_B_RST = 9'd256;

  typedef enum logic [1:0] {
    REG_TERM_A = 2'd0,
    REG_TERM_B = 2'd1,
    REG_COMM_A = 2'd2,
    REG_COMM_B = 2'd3
  } reg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SKIP    = 2'd0,
    CLS_TAG     = 2'd1,
    CLS_VALUE   = 2'd2,
    CLS_VERDICT = 2'd3
  } char_class_t;

  typedef struct packed {
    logic in_quotes;
    logic escaped;
    logic in_comment;
    logic tag_done;
    logic value_done;
    logic line_bad;
    logic tag_seen;
    logic value_seen;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '0;

endpackage

@@ design/clt_in_if.sv @@
// ----------------------------------------------------------------------------
// clt_in_if
// character channel into the tokenizer
// ----------------------------------------------------------------------------
interface clt_in_if
  import clt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

@@ design/clt_out_if.sv @@
// ----------------------------------------------------------------------------
// clt_out_if
// classified character channel out of the tokenizer
// ----------------------------------------------------------------------------
interface clt_out_if
  import clt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] char_class;
  logic [CHAR_W-1:0]  out_char;
  logic               line_ok;
  logic               line_blank;

  modport source (output valid, output char_class, output out_char, output line_ok,
                  output line_blank, input ready);
  modport sink   (input valid, input char_class, input out_char, input line_ok,
                  input line_blank, output ready);
endinterface

@@ design/config_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// config_line_tokenizer_core
// classifies one character of a configuration line per item as skipped, tag
// or value, and gives the line verdict on an end-of-line item
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_ch     sink       valid/ready    char_code, line_end
//  out_ch    source     valid/ready    char_class, out_char, line_ok, line_blank
//  cfg       apb slave  psel/penable   paddr[3:2] selects one of four 9-bit codes
//
//  one item per cycle sustained while out_ch.ready holds; an item is registered
//  in the input register and leaves through the result register
//  the line state update between the two registers sets the rate
//  synchronous active-low reset clears both stages and line state, presets codes
//  a stalled result holds in the result register while one more item waits
//  in the input register; only then does in_ch.ready fall
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module config_line_tokenizer_core
  import clt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  clt_in_if.sink            in_ch,
  clt_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [CODE_W-1:0] term_a_r, term_b_r, comm_a_r, comm_b_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // input stage
  logic              in_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              end_r;

  // result stage
  logic              out_valid_r;
  char_class_t       class_r, class_nxt;
  logic [CHAR_W-1:0] char_out_r, char_out_nxt;
  logic              ok_r, ok_nxt;
  logic              blank_r, blank_nxt;

  line_state_t       st_r, st_nxt;

  logic              advance;
  logic              in_take;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_a_r <= TERM_A_RST;
      term_b_r <= TERM_B_RST;
      comm_a_r <= COMM_A_RST;
      comm_b_r <= COMM_B_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TERM_A: term_a_r <= pwdata[CODE_W-1:0];
        REG_TERM_B: term_b_r <= pwdata[CODE_W-1:0];
        REG_COMM_A: comm_a_r <= pwdata[CODE_W-1:0];
        REG_COMM_B: comm_b_r <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TERM_A: prdata = {{(DATA_W-CODE_W){1'b0}}, term_a_r};
      REG_TERM_B: prdata = {{(DATA_W-CODE_W){1'b0}}, term_b_r};
      REG_COMM_A: prdata = {{(DATA_W-CODE_W){1'b0}}, comm_a_r};
      REG_COMM_B: prdata = {{(DATA_W-CODE_W){1'b0}}, comm_b_r};
      default:    prdata = '0;
    endcase
  end

  // handshake between the stages
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_ch.char_code;
      end_r  <= in_ch.line_end;
    end
  end

  // per-character rules
  always_comb begin
    logic [CODE_W-1:0] c9;
    logic is_blank, plain, is_term, is_comm, skip, slash_set;
    c9           = {1'b0, char_r};
    is_blank     = (char_r == CH_SPACE) || (char_r == CH_TAB);
    plain        = !st_r.in_quotes && !st_r.escaped;
    is_term      = (c9 == term_a_r) || (c9 == term_b_r);
    is_comm      = (c9 == comm_a_r) || (c9 == comm_b_r);
    skip         = 1'b0;
    slash_set    = 1'b0;
    st_nxt       = st_r;
    class_nxt    = CLS_SKIP;
    char_out_nxt = '0;
    ok_nxt       = 1'b0;
    blank_nxt    = 1'b0;
    if (end_r) begin
      blank_nxt = !st_r.tag_seen && !st_r.value_seen;
      class_nxt = CLS_VERDICT;
      ok_nxt    = !st_r.line_bad && !st_r.in_quotes && !st_r.escaped &&
                  (blank_nxt || (st_r.tag_seen && st_r.value_seen));
      st_nxt    = LINE_CLEAR;
    end else if (!st_r.line_bad && !st_r.in_comment) begin
      if (char_r == CH_QUOTE && !st_r.escaped) begin
        st_nxt.in_quotes = !st_r.in_quotes;
        skip             = 1'b1;
      end
      if (!skip && is_blank && plain) begin
        skip = st_r.tag_done ? !st_r.value_seen : !st_r.tag_seen;
      end
      if (!skip && is_comm && plain) begin
        st_nxt.in_comment = 1'b1;
        skip              = 1'b1;
      end
      if (!skip && !is_blank && st_r.tag_done && st_r.value_done) begin
        st_nxt.line_bad = 1'b1;
        skip            = 1'b1;
      end
      if (!skip && is_term && plain) begin
        priority if (!st_r.tag_done) begin
          st_nxt.tag_done = 1'b1;
        end else if (!st_r.value_done) begin
          st_nxt.value_done = 1'b1;
        end else begin
          st_nxt.line_bad = !is_blank;
        end
        skip = 1'b1;
      end
      if (!skip && char_r == CH_BSLASH && !st_r.escaped) begin
        st_nxt.escaped = 1'b1;
        slash_set      = 1'b1;
        skip           = 1'b1;
      end
      if (!slash_set) begin
        st_nxt.escaped = 1'b0;
      end
      if (!skip) begin
        char_out_nxt = char_r;
        if (!st_r.tag_done) begin
          class_nxt       = CLS_TAG;
          st_nxt.tag_seen = 1'b1;
        end else begin
          class_nxt         = CLS_VALUE;
          st_nxt.value_seen = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= LINE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      class_r    <= class_nxt;
      char_out_r <= char_out_nxt;
      ok_r       <= ok_nxt;
      blank_r    <= blank_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_class = class_r;
  assign out_ch.out_char   = char_out_r;
  assign out_ch.line_ok    = ok_r;
  assign out_ch.line_blank = blank_r;

  // a verdict leaves the line state clear
  `ASSERT_CLK(a_clear_after_verdict, advance && end_r |=> st_r == LINE_CLEAR)
  // a bad or commented line stays so until its end
  `ASSERT_CLK(a_sticky_stop, advance && !end_r && (st_r.line_bad || st_r.in_comment) |=> (st_r.line_bad || st_r.in_comment))
  // only verdicts carry verdict flags
  `ASSERT_CLK(a_flags_on_verdict, out_valid_r && class_r != CLS_VERDICT |-> !ok_r && !blank_r)
  // skipped items pass no character
  `ASSERT_CLK(a_skip_no_char, out_valid_r && class_r == CLS_SKIP |-> char_out_r == '0)
  // backpressure only with both stages full
  `ASSERT_ALWAYS(a_ready_low_full, rst_n && !in_ch.ready |-> in_valid_r && out_valid_r)

endmodule

@@ test/config_line_tokenizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// config_line_tokenizer_core_tb
// drives configuration lines character by character through the tokenizer,
// predicts the class of every character and the verdict of every line, and
// compares each result; the terminator and comment codes are rewritten over
// the apb port between phases, with back-pressure on both channels
// ----------------------------------------------------------------------------
module config_line_tokenizer_core_tb
  import clt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 145;

  typedef struct packed {
    char_class_t       cls;
    logic [CHAR_W-1:0] ch;
    logic              ok;
    logic              blank;
  } token_t;

  class line_scoreboard;
    logic [CODE_W-1:0] codes [4];
    line_state_t       st;
    token_t            expected_q [$];
    int                errors;

    function new();
      codes[REG_TERM_A] = TERM_A_RST;
      codes[REG_TERM_B] = TERM_B_RST;
      codes[REG_COMM_A] = COMM_A_RST;
      codes[REG_COMM_B] = COMM_B_RST;
      st = LINE_CLEAR;
      errors = 0;
    endfunction

    function void set_code(reg_idx_t idx, logic [CODE_W-1:0] code);
      codes[idx] = code;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_input(logic [CHAR_W-1:0] c, logic eol);
      token_t t;
      logic   ws, bare, term_hit, comm_hit, drop, esc_now;
      t = '{CLS_SKIP, 8'h00, 1'b0, 1'b0};
      if (eol) begin
        t.cls   = CLS_VERDICT;
        t.blank = !st.tag_seen && !st.value_seen;
        t.ok    = !st.line_bad && !st.in_quotes && !st.escaped &&
                  (t.blank || (st.tag_seen && st.value_seen));
        st = LINE_CLEAR;
      end else if (!st.line_bad && !st.in_comment) begin
        ws       = (c == CH_SPACE) || (c == CH_TAB);
        bare     = !st.in_quotes && !st.escaped;
        term_hit = ({1'b0, c} == codes[REG_TERM_A]) || ({1'b0, c} == codes[REG_TERM_B]);
        comm_hit = ({1'b0, c} == codes[REG_COMM_A]) || ({1'b0, c} == codes[REG_COMM_B]);
        drop     = 1'b0;
        esc_now  = 1'b0;
        if (c == CH_QUOTE && !st.escaped) begin
          st.in_quotes = !st.in_quotes;
          drop = 1'b1;
        end
        if (!drop && ws && !st.in_quotes && !st.escaped)
          drop = st.tag_done ? !st.value_seen : !st.tag_seen;
        if (!drop && comm_hit && bare) begin
          st.in_comment = 1'b1;
          drop = 1'b1;
        end
        if (!drop && !ws && st.tag_done && st.value_done) begin
          st.line_bad = 1'b1;
          drop = 1'b1;
        end
        if (!drop && term_hit && bare) begin
          if (!st.tag_done) st.tag_done = 1'b1;
          else if (!st.value_done) st.value_done = 1'b1;
          else if (!ws) st.line_bad = 1'b1;
          drop = 1'b1;
        end
        if (!drop && c == CH_BSLASH && !st.escaped) begin
          st.escaped = 1'b1;
          esc_now = 1'b1;
          drop = 1'b1;
        end
        if (!esc_now) st.escaped = 1'b0;
        if (!drop) begin
          t.ch = c;
          if (!st.tag_done) begin
            t.cls = CLS_TAG;
            st.tag_seen = 1'b1;
          end else begin
            t.cls = CLS_VALUE;
            st.value_seen = 1'b1;
          end
        end
      end
      expected_q.push_back(t);
    endfunction

    task check_result(logic [CLASS_W-1:0] cls, logic [CHAR_W-1:0] ch, logic ok,
                      logic blank);
      token_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result class %0d with nothing expected", cls));
      end else begin
        e = expected_q.pop_front();
        if (cls !== e.cls) report($sformatf("class %0d, expected %0d", cls, e.cls));
        if (ch !== e.ch) report($sformatf("char %0d, expected %0d", ch, e.ch));
        if (ok !== e.ok) report($sformatf("line_ok %0b, expected %0b", ok, e.ok));
        if (blank !== e.blank)
          report($sformatf("line_blank %0b, expected %0b", blank, e.blank));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  clt_in_if  in_ch ();
  clt_out_if out_ch ();

  config_line_tokenizer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  line_scoreboard    sb = new();
  int                send_idle_pct = 16;
  int                recv_idle_pct = 58;
  int                phase_items;
  int                quiet_cycles;
  logic [CHAR_W-1:0] line_buf [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.char_code, in_ch.line_end);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.char_class, out_ch.out_char, out_ch.line_ok,
                        out_ch.line_blank);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("config_line_tokenizer_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_item(logic [CHAR_W-1:0] c, logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.line_end  <= eol;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    phase_items++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic [CHAR_W-1:0] eol_char);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(eol_char, 1'b1);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CODE_W-1:0] code);
    logic [DATA_W-1:0] w;
    w = $urandom();
    w[CODE_W-1:0] = code;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_code(idx, code);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(code))
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata, code));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every result is back and the pipeline has drained
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_code(logic [CODE_W-1:0] a,
                                                  logic [CODE_W-1:0] b);
    if (!a[8] && (b[8] || $urandom_range(1))) return a[7:0];
    if (!b[8]) return b[7:0];
    return CHAR_W'($urandom_range(33, 126));
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(2)) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void push_comment();
    line_buf.push_back(pick_code(sb.codes[REG_COMM_A], sb.codes[REG_COMM_B]));
    repeat ($urandom_range(4)) line_buf.push_back(CHAR_W'($urandom_range(255)));
  endfunction

  function automatic void push_field();
    int r;
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(99);
      if (r < 70) begin
        line_buf.push_back(CHAR_W'($urandom_range(1) ? $urandom_range(97, 122)
                                                     : $urandom_range(48, 57)));
      end else if (r < 80) begin
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(CHAR_W'($urandom_range(255)));
      end else if (r < 90) begin
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(3))
            0: line_buf.push_back(CH_SPACE);
            1: line_buf.push_back(pick_code(sb.codes[REG_TERM_A], sb.codes[REG_TERM_B]));
            2: line_buf.push_back(pick_code(sb.codes[REG_COMM_A], sb.codes[REG_COMM_B]));
            default: line_buf.push_back(CHAR_W'($urandom_range(97, 122)));
          endcase
        end
        line_buf.push_back(CH_QUOTE);
      end else begin
        line_buf.push_back(CHAR_W'($urandom_range(33, 126)));
      end
    end
  endfunction

  task automatic send_line();
    int kind, flaw;
    kind = $urandom_range(99);
    flaw = (kind >= 85) ? $urandom_range(4) : -1;
    line_buf.delete();
    if (kind < 12) begin
      repeat ($urandom_range(12)) line_buf.push_back(CHAR_W'($urandom_range(255)));
    end else if (kind < 22) begin
      push_blanks();
      if ($urandom_range(1)) push_comment();
    end else begin
      push_blanks();
      push_field();
      push_blanks();
      if (flaw != 0) line_buf.push_back(pick_code(sb.codes[REG_TERM_A], sb.codes[REG_TERM_B]));
      push_blanks();
      if (flaw != 1) push_field();
      push_blanks();
      case (flaw)
        2: begin
          line_buf.push_back(pick_code(sb.codes[REG_TERM_A], sb.codes[REG_TERM_B]));
          push_blanks();
          push_field();
        end
        3: line_buf.push_back(CH_QUOTE);
        4: line_buf.push_back(CH_BSLASH);
        default: ;
      endcase
      if ($urandom_range(2) == 0) push_comment();
    end
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    logic [CODE_W-1:0] set [4];
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.line_end  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 16 : (p < 4) ? 58 : 0;
      recv_idle_pct = (p < 2) ? 58 : (p < 4) ? 16 : 0;
      phase_items = 0;
      if (p == 0) begin
        // blanks around tag and value, quoted comment char, escaped terminator
        send_text(" k\t= v", 8'hFF);
        send_text("\"# \"=\\=", 8'h00);
        // extra field after the value, then everything skipped
        send_item(8'hFF, 1'b0);
        send_item("=", 1'b0);
        send_item(8'h00, 1'b0);
        send_item("=", 1'b0);
        send_item("x", 1'b0);
        send_item("#", 1'b0);
        send_item(8'h00, 1'b1);
        // comment only line
        send_text("#z", 8'hFF);
      end else begin
        settle();
        case (p)
          1: set = '{9'd58, 9'd61, 9'd59, 9'd35};
          // blank terminator; codes above 255 never match
          2: set = '{9'd32, 9'd256, 9'd511, 9'd35};
          3: set = '{9'd0, 9'd255, 9'd256, 9'd300};
          4: set = '{9'd9, 9'd61, 9'd47, 9'd59};
          default: foreach (set[i]) set[i] = CODE_W'($urandom_range(511));
        endcase
        write_reg(REG_TERM_A, set[0]);
        write_reg(REG_TERM_B, set[1]);
        write_reg(REG_COMM_A, set[2]);
        write_reg(REG_COMM_B, set[3]);
      end
      while (phase_items < PHASE_ITEMS) send_line();
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("config_line_tokenizer_core_tb: done, clean");
    end else begin
      $display("config_line_tokenizer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
